// ===== design/ftq_pkg.sv =====
// Shared types and constants for the fetch target queue.
package ftq_pkg;

    localparam int DATA_W = 64;
    localparam int CMD_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ            = 3'd0,
        CMD_FETCH_USE      = 3'd1,
        CMD_COMMIT_DEQ     = 3'd2,
        CMD_PRECHECK_RESTORE = 3'd3,
        CMD_COMMIT_RESTORE = 3'd4,
        CMD_STATUS         = 3'd5
    } ftq_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] entry_data;
    } ftq_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] fetch_head_data;
        logic              fetch_head_valid;
        logic [DATA_W-1:0] commit_head_data;
        logic              commit_head_valid;
        logic              queue_full;
        logic              rejected;
    } ftq_rsp_t;

endpackage

// ===== design/fetch_target_queue_three_pointer.sv =====
// Fetch target queue: circular entry store with write, fetch and commit pointers.
//
// Usage:
//   An item is a command and a payload on request; it is taken at a rising
//   edge where start is high and busy is low. busy stays low, so a new item
//   may be issued every cycle.
//   Each item gives one result on result, marked by done for exactly one
//   cycle, in the cycle right after the item was taken.
//   Throughput is one item per cycle: pointer updates are single increments
//   and both heads are read from the two-read-port entry memory at the edge
//   that takes the item, with the written entry forwarded on a same-slot hit.
//   The receiver cannot stall; a result not taken in its cycle is gone.
//   Reset clears the three pointers and done. The entry memory is not
//   cleared; a head must not be read from a slot that no enqueue has written.
//   Enqueue on a full queue and fetch use or commit dequeue on an empty
//   pointer are ignored and reported through rejected.
module fetch_target_queue_three_pointer #(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ftq_pkg::ftq_req_t request,
    output logic              done,
    output ftq_pkg::ftq_rsp_t result
);
    import ftq_pkg::*;

    localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = SW + 1;
    localparam logic [PW-1:0] PTR_LAST = PW'(2 * DEPTH - 1);
    localparam logic [PW-1:0] DEPTH_P  = PW'(DEPTH);

    logic [ENTRY_WIDTH-1:0] mem [DEPTH];

    logic [PW-1:0] w_reg, w_next;
    logic [PW-1:0] f_reg, f_next;
    logic [PW-1:0] c_reg, c_next;

    logic                   done_reg;
    logic                   fv_reg, cv_reg, full_reg, rej_reg;
    logic                   fwd_f_reg, fwd_c_reg;
    logic [ENTRY_WIDTH-1:0] rd_f_reg, rd_c_reg, wdata_reg;

    logic                   accept;
    logic                   full_now;
    logic                   rej_next;
    logic                   wr_en;
    logic [SW-1:0]          wr_slot, rf_slot, rc_slot;
    logic [ENTRY_WIDTH-1:0] wr_data;
    logic [ENTRY_WIDTH-1:0] fetch_raw, commit_raw;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = (p >= DEPTH_P) ? p - DEPTH_P : p;
        slot_of = s[SW-1:0];
    endfunction

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign full_now = (c_reg != w_reg) && (slot_of(c_reg) == slot_of(w_reg));
    assign wr_slot  = slot_of(w_reg);
    assign wr_data  = request.entry_data[ENTRY_WIDTH-1:0];

    always_comb
    begin
        w_next   = w_reg;
        f_next   = f_reg;
        c_next   = c_reg;
        rej_next = 1'b0;
        wr_en    = 1'b0;
        case (request.command)
            CMD_ENQ:
            begin
                if (full_now)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    wr_en  = accept;
                    w_next = ptr_inc(w_reg);
                end
            end
            CMD_FETCH_USE:
            begin
                if (f_reg == w_reg)
                    rej_next = 1'b1;
                else
                    f_next = ptr_inc(f_reg);
            end
            CMD_COMMIT_DEQ:
            begin
                if (c_reg == w_reg)
                    rej_next = 1'b1;
                else
                    c_next = ptr_inc(c_reg);
            end
            CMD_PRECHECK_RESTORE:
            begin
                w_next = ptr_inc(f_reg);
            end
            CMD_COMMIT_RESTORE:
            begin
                w_next = ptr_inc(c_reg);
                f_next = ptr_inc(c_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign rf_slot = slot_of(f_next);
    assign rc_slot = slot_of(c_next);

    // entry memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_slot] <= wr_data;
        if (accept)
        begin
            rd_f_reg  <= mem[rf_slot];
            rd_c_reg  <= mem[rc_slot];
            fwd_f_reg <= wr_en && (rf_slot == wr_slot);
            fwd_c_reg <= wr_en && (rc_slot == wr_slot);
            wdata_reg <= wr_data;
            fv_reg    <= f_next != w_next;
            cv_reg    <= c_next != w_next;
            full_reg  <= (c_next != w_next) && (rc_slot == slot_of(w_next));
            rej_reg   <= rej_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= '0;
            f_reg    <= '0;
            c_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                w_reg <= w_next;
                f_reg <= f_next;
                c_reg <= c_next;
            end
        end
    end

    assign fetch_raw  = fwd_f_reg ? wdata_reg : rd_f_reg;
    assign commit_raw = fwd_c_reg ? wdata_reg : rd_c_reg;

    assign done                     = done_reg;
    assign result.fetch_head_data   = fv_reg ? DATA_W'(fetch_raw) : '0;
    assign result.fetch_head_valid  = fv_reg;
    assign result.commit_head_data  = cv_reg ? DATA_W'(commit_raw) : '0;
    assign result.commit_head_valid = cv_reg;
    assign result.queue_full        = full_reg;
    assign result.rejected          = rej_reg;

`ifndef SYNTH
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("item taken without a result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without an item");

    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.queue_full) |-> result.commit_head_valid)
        else $error("full queue reported without a commit head");

    a_enq_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.command == CMD_ENQ && !full_now) |=> w_reg != $past(w_reg))
        else $error("accepted enqueue did not advance the write pointer");
`endif

endmodule
